[sv/cds_pkg.sv]
// Package for the calendar date stepper: field widths, command and status
// codes, reset date, and the small calendar helper functions.
// No dependencies; every other file of the block imports it.
package cds_pkg;

  // Width of the stored year. The input and output year fields stay 16 bits.
  localparam int YEAR_BITS = 16;

  localparam int CMD_W    = 2;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int YIN_W    = 16;
  localparam int STATUS_W = 3;
  localparam int R25_W    = 5;
  // Width in which a loaded year is range checked.
  localparam int CMP_W    = (YEAR_BITS > YIN_W) ? YEAR_BITS : YIN_W;

  typedef logic [YEAR_BITS-1:0] year_t;
  typedef logic [MONTH_W-1:0]   month_t;
  typedef logic [DAY_W-1:0]     day_t;
  typedef logic [R25_W-1:0]     r25_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [CMD_W-1:0]     cmd_t;

  localparam year_t YEAR_MAX = {YEAR_BITS{1'b1}};
  localparam year_t YEAR_MIN = year_t'(1);

  // Command codes.
  localparam cmd_t CMD_LOAD = 2'd0;
  localparam cmd_t CMD_FWD  = 2'd1;
  localparam cmd_t CMD_BACK = 2'd2;

  // Status codes.
  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_BAD_MONTH = 3'd1;
  localparam status_t ST_BAD_YEAR  = 3'd2;
  localparam status_t ST_BAD_DAY   = 3'd3;
  localparam status_t ST_LIMIT     = 3'd4;

  localparam month_t MONTH_JAN = 4'd1;
  localparam month_t MONTH_FEB = 4'd2;
  localparam month_t MONTH_DEC = 4'd12;
  localparam day_t   DAY_FIRST = 5'd1;
  localparam day_t   DAY_DEC   = 5'd31;

  // Reset date and the year's remainder modulo 25 that goes with it.
  localparam month_t RST_MONTH = MONTH_JAN;
  localparam day_t   RST_DAY   = DAY_FIRST;
  localparam year_t  RST_YEAR  = year_t'(1930);
  localparam r25_t   RST_R25   = r25_t'(1930 % 25);
  localparam r25_t   R25_LAST  = r25_t'(24);

  // Reciprocal of 25 scaled by 2^24, rounded up; exact for 16-bit dividends.
  localparam int    RECIP_SH  = 24;
  localparam int    RECIP_W   = 20;
  localparam int    PROD_W    = YIN_W + RECIP_W;
  localparam int    QUO_W     = PROD_W - RECIP_SH;
  localparam logic [RECIP_W-1:0] RECIP25 = RECIP_W'(((1 << RECIP_SH) + 24) / 25);

  typedef struct packed {
    cmd_t                cmd;
    month_t              new_month;
    day_t                new_day;
    logic [YIN_W-1:0]    new_year;
  } req_t;

  typedef struct packed {
    month_t              month_out;
    day_t                day_out;
    logic [YIN_W-1:0]    year_out;
    status_t             status;
  } res_t;

  // Remainder of a 16-bit year modulo 25.
  function automatic r25_t mod25(input logic [YIN_W-1:0] y);
    logic [PROD_W-1:0] prod;
    logic [QUO_W-1:0]  quo;
    logic [YIN_W-1:0]  rem;
    prod = PROD_W'(y) * PROD_W'(RECIP25);
    quo  = prod[PROD_W-1:RECIP_SH];
    rem  = y - YIN_W'(YIN_W'(quo) * YIN_W'(25));
    return rem[R25_W-1:0];
  endfunction

  // Leap year from the low four bits of the year and its remainder mod 25:
  // a multiple of 100 is a multiple of 4 and 25, a multiple of 400 is a
  // multiple of 16 and 25.
  function automatic logic is_leap(input logic [3:0] ylo, input r25_t r25);
    logic div25;
    div25 = (r25 == '0);
    return (!div25 && (ylo[1:0] == 2'd0)) || (div25 && (ylo == 4'd0));
  endfunction

  // Days in a month; zero for a code that is not a month.
  function automatic day_t month_len(input month_t m, input logic leap);
    day_t len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      MONTH_FEB:                                  len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

[sv/cds_if.sv]
// Channel interfaces of the calendar date stepper: the command request
// channel and the result channel, each with valid/ready and payload.
// Depends on cds_pkg.
interface cds_req_if import cds_pkg::*; ();
  logic             valid;
  logic             ready;
  cmd_t             cmd;
  month_t           new_month;
  day_t             new_day;
  logic [YIN_W-1:0] new_year;

  modport source (output valid, cmd, new_month, new_day, new_year, input ready);
  modport sink   (input valid, cmd, new_month, new_day, new_year, output ready);
endinterface

interface cds_res_if import cds_pkg::*; ();
  logic             valid;
  logic             ready;
  month_t           month_out;
  day_t             day_out;
  logic [YIN_W-1:0] year_out;
  status_t          status;

  modport source (output valid, month_out, day_out, year_out, status, input ready);
  modport sink   (input valid, month_out, day_out, year_out, status, output ready);
endinterface

[sv/cds_in_stage.sv]
// Input register of the calendar date stepper: captures one command request
// and hands it to the date logic when the result register can take it.
// Depends on cds_pkg and cds_req_if.
module cds_in_stage import cds_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  cds_req_if.sink   in_req,
  input  logic      adv,
  output logic      fire,
  output req_t      req
);

  logic valid_r;
  logic valid_nxt;
  req_t req_r;
  logic take;

  assign in_req.ready = !valid_r || adv;
  assign take         = in_req.valid && in_req.ready;
  assign fire         = valid_r && adv;
  assign req          = req_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (fire) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req_r <= '{cmd: in_req.cmd, new_month: in_req.new_month,
                 new_day: in_req.new_day, new_year: in_req.new_year};
    end
  end

endmodule

[sv/cds_date_core.sv]
// Date state of the calendar date stepper and the combinational logic that
// loads, advances or rewinds it for one command.
// Depends on cds_pkg.
module cds_date_core import cds_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic fire,
  input  req_t req,
  output res_t res
);

  month_t  month_r, month_nxt;
  day_t    day_r, day_nxt;
  year_t   year_r, year_nxt;
  r25_t    r25_r, r25_nxt;
  status_t status;

  logic             cur_leap;
  day_t             cur_len;
  day_t             prev_len;
  month_t           prev_month;
  r25_t             ld_r25;
  logic             ld_leap;
  day_t             ld_len;
  logic [CMP_W-1:0] ld_year;
  logic [CMP_W-1:0] out_year;

  assign cur_leap   = is_leap(year_r[3:0], r25_r);
  assign cur_len    = month_len(month_r, cur_leap);
  assign prev_month = month_r - MONTH_JAN;
  assign prev_len   = month_len(prev_month, cur_leap);

  assign ld_year = CMP_W'(req.new_year);
  assign ld_r25  = mod25(req.new_year);
  assign ld_leap = is_leap(req.new_year[3:0], ld_r25);
  assign ld_len  = month_len(req.new_month, ld_leap);

  always_comb begin
    month_nxt = month_r;
    day_nxt   = day_r;
    year_nxt  = year_r;
    r25_nxt   = r25_r;
    status    = ST_OK;
    case (req.cmd)
      CMD_LOAD: begin
        if (req.new_month < MONTH_JAN || req.new_month > MONTH_DEC) begin
          status = ST_BAD_MONTH;
        end else if (ld_year == '0 || ld_year > CMP_W'(YEAR_MAX)) begin
          status = ST_BAD_YEAR;
        end else if (req.new_day < DAY_FIRST || req.new_day > ld_len) begin
          status = ST_BAD_DAY;
        end else begin
          month_nxt = req.new_month;
          day_nxt   = req.new_day;
          year_nxt  = year_t'(ld_year);
          r25_nxt   = ld_r25;
        end
      end
      CMD_FWD: begin
        if (day_r < cur_len) begin
          day_nxt = day_r + DAY_FIRST;
        end else if (month_r >= MONTH_DEC) begin
          if (year_r == YEAR_MAX) begin
            status = ST_LIMIT;
          end else begin
            day_nxt   = DAY_FIRST;
            month_nxt = MONTH_JAN;
            year_nxt  = year_r + YEAR_MIN;
            r25_nxt   = (r25_r == R25_LAST) ? '0 : r25_r + r25_t'(1);
          end
        end else begin
          day_nxt   = DAY_FIRST;
          month_nxt = month_r + MONTH_JAN;
        end
      end
      CMD_BACK: begin
        if (day_r > DAY_FIRST) begin
          day_nxt = day_r - DAY_FIRST;
        end else if (month_r <= MONTH_JAN) begin
          if (year_r <= YEAR_MIN) begin
            status = ST_LIMIT;
          end else begin
            // December 31 of the year before.
            month_nxt = MONTH_DEC;
            day_nxt   = DAY_DEC;
            year_nxt  = year_r - YEAR_MIN;
            r25_nxt   = (r25_r == '0) ? R25_LAST : r25_r - r25_t'(1);
          end
        end else begin
          month_nxt = prev_month;
          day_nxt   = prev_len;
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
  end

  assign out_year = CMP_W'(year_nxt);
  assign res = '{month_out: month_nxt, day_out: day_nxt,
                 year_out: out_year[YIN_W-1:0], status: status};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      month_r <= RST_MONTH;
      day_r   <= RST_DAY;
      year_r  <= RST_YEAR;
      r25_r   <= RST_R25;
    end else if (fire) begin
      month_r <= month_nxt;
      day_r   <= day_nxt;
      year_r  <= year_nxt;
      r25_r   <= r25_nxt;
    end
  end

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    month_r >= MONTH_JAN && month_r <= MONTH_DEC)
    else $error("stored month out of range");

  a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
    day_r >= DAY_FIRST && day_r <= cur_len)
    else $error("stored day outside its month");

  a_year_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    year_r != '0)
    else $error("stored year is zero");

  a_r25_range: assert property (@(posedge clk) disable iff (!rst_n)
    r25_r <= R25_LAST)
    else $error("year remainder mod 25 out of range");

  a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
    fire && status != ST_OK |=>
      $stable(month_r) && $stable(day_r) && $stable(year_r) && $stable(r25_r))
    else $error("date changed on a rejected or limited command");

endmodule

[sv/cds_out_stage.sv]
// Result register of the calendar date stepper: holds one result until the
// sink takes it and tells the input side when it may advance.
// Depends on cds_pkg and cds_res_if.
module cds_out_stage import cds_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  res_t      res,
  output logic      adv,
  cds_res_if.source out_res
);

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  assign adv = !valid_r || out_res.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (fire) begin
      valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_res.valid     = valid_r;
  assign out_res.month_out = res_r.month_out;
  assign out_res.day_out   = res_r.day_out;
  assign out_res.year_out  = res_r.year_out;
  assign out_res.status    = res_r.status;

endmodule

[sv/calendar_date_stepper.sv]
// Gregorian date counter that takes one command request per clock cycle when
// the sink keeps up, and returns one result for each: the date after the
// command and a status code. A request either loads a date (checked for month,
// then year, then day against the month's length with leap-year February),
// steps one day forward or steps one day back. A rejected load or a step past
// the first or last representable day leaves the date unchanged and reports
// why. Every request passes through an input register and a result register;
// it leaves the input register when the result register is free or being
// emptied. A new request can be accepted every cycle while the sink keeps
// taking results. The rate is set by the loop through the date registers,
// which are read and rewritten in the same cycle by each request. While a
// finished result waits for the sink, the input register still takes one new
// request; the next one is held off until the sink takes the waiting result.
// After reset the date is January 1, 1930.
// Depends on cds_pkg, cds_if, cds_in_stage, cds_date_core and cds_out_stage.
module calendar_date_stepper import cds_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  cds_req_if.sink   in_req,
  cds_res_if.source out_res
);

  logic fire;
  logic adv;
  req_t req;
  res_t res;

  // Input register; it releases its request when the result register is
  // free or being emptied this cycle.
  cds_in_stage u_in (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (in_req),
    .adv    (adv),
    .fire   (fire),
    .req    (req)
  );

  // Date registers and the logic that applies one command per cycle while fire is high.
  cds_date_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .req   (req),
    .res   (res)
  );

  // Result register toward the sink.
  cds_out_stage u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .res     (res),
    .adv     (adv),
    .out_res (out_res)
  );

endmodule

[tb/sv/calendar_date_stepper_test.sv]
// Self-checking testbench for calendar_date_stepper: it sends date command
// requests, predicts each date and status, and checks every returned result.
// Depends on cds_pkg, cds_if and the calendar_date_stepper RTL.
module calendar_date_stepper_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cds_pkg::*;

  // The block ignores the fourth command code; it gets a name of its own here.
  localparam cmd_t CMD_NONE = 2'd3;

  localparam int DIR_ROWS     = 26;
  localparam int RANDOM_REQS  = 1925;
  localparam int TOTAL_REQS   = DIR_ROWS + RANDOM_REQS;
  // No idling on either side for the last stretch of the run.
  localparam int QUIET_TAIL   = 300;
  // The sink stops taking results for a long stretch once this many requests
  // have gone in, so the block backs up into its input.
  localparam int HOLD_AFTER   = 600;
  localparam int HOLD_CYCLES  = 120;
  // Cycles allowed at the end, after all expected results, to catch any stray result.
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 200000;

  // One row of the directed table. Where pinned is set, the row carries the
  // result that it must produce; otherwise the predictor decides.
  typedef struct packed {
    cmd_t             cmd;
    month_t           new_month;
    day_t             new_day;
    logic [YIN_W-1:0] new_year;
    logic             pinned;
    month_t           month_out;
    day_t             day_out;
    logic [YIN_W-1:0] year_out;
    status_t          status;
  } dir_row_t;

  // The date starts at January 1, 1930 after reset. The rows walk both ways
  // across the year end, reject each bad field in turn (month first, then
  // year, then day, including February 29 of a century that is not a leap
  // year), run into both ends of the year range, and try the unused command.
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{CMD_FWD,  4'd0,  5'd0,  16'd0,     1'b1, 4'd1,  5'd2,  16'd1930,  ST_OK},
    '{CMD_BACK, 4'd0,  5'd0,  16'd0,     1'b1, 4'd1,  5'd1,  16'd1930,  ST_OK},
    '{CMD_BACK, 4'd0,  5'd0,  16'd0,     1'b1, 4'd12, 5'd31, 16'd1929,  ST_OK},
    '{CMD_LOAD, 4'd0,  5'd15, 16'd65535, 1'b1, 4'd12, 5'd31, 16'd1929,  ST_BAD_MONTH},
    '{CMD_LOAD, 4'd13, 5'd5,  16'd2000,  1'b1, 4'd12, 5'd31, 16'd1929,  ST_BAD_MONTH},
    '{CMD_LOAD, 4'd15, 5'd31, 16'd0,     1'b1, 4'd12, 5'd31, 16'd1929,  ST_BAD_MONTH},
    '{CMD_LOAD, 4'd1,  5'd1,  16'd0,     1'b1, 4'd12, 5'd31, 16'd1929,  ST_BAD_YEAR},
    '{CMD_LOAD, 4'd1,  5'd0,  16'd1,     1'b1, 4'd12, 5'd31, 16'd1929,  ST_BAD_DAY},
    '{CMD_LOAD, 4'd4,  5'd31, 16'd2001,  1'b1, 4'd12, 5'd31, 16'd1929,  ST_BAD_DAY},
    '{CMD_LOAD, 4'd2,  5'd29, 16'd1900,  1'b1, 4'd12, 5'd31, 16'd1929,  ST_BAD_DAY},
    '{CMD_LOAD, 4'd2,  5'd29, 16'd2000,  1'b1, 4'd2,  5'd29, 16'd2000,  ST_OK},
    '{CMD_FWD,  4'd0,  5'd0,  16'd0,     1'b0, 4'd0,  5'd0,  16'd0,     ST_OK},
    '{CMD_BACK, 4'd0,  5'd0,  16'd0,     1'b0, 4'd0,  5'd0,  16'd0,     ST_OK},
    '{CMD_LOAD, 4'd2,  5'd28, 16'd2100,  1'b1, 4'd2,  5'd28, 16'd2100,  ST_OK},
    '{CMD_FWD,  4'd0,  5'd0,  16'd0,     1'b0, 4'd0,  5'd0,  16'd0,     ST_OK},
    '{CMD_LOAD, 4'd12, 5'd31, 16'd65535, 1'b1, 4'd12, 5'd31, 16'd65535, ST_OK},
    '{CMD_FWD,  4'd0,  5'd0,  16'd0,     1'b1, 4'd12, 5'd31, 16'd65535, ST_LIMIT},
    '{CMD_BACK, 4'd0,  5'd0,  16'd0,     1'b0, 4'd0,  5'd0,  16'd0,     ST_OK},
    '{CMD_LOAD, 4'd1,  5'd1,  16'd1,     1'b1, 4'd1,  5'd1,  16'd1,     ST_OK},
    '{CMD_BACK, 4'd0,  5'd0,  16'd0,     1'b1, 4'd1,  5'd1,  16'd1,     ST_LIMIT},
    '{CMD_FWD,  4'd0,  5'd0,  16'd0,     1'b0, 4'd0,  5'd0,  16'd0,     ST_OK},
    '{CMD_NONE, 4'd15, 5'd31, 16'd65535, 1'b1, 4'd1,  5'd2,  16'd1,     ST_OK},
    '{CMD_LOAD, 4'd3,  5'd1,  16'd1600,  1'b1, 4'd3,  5'd1,  16'd1600,  ST_OK},
    '{CMD_BACK, 4'd0,  5'd0,  16'd0,     1'b0, 4'd0,  5'd0,  16'd0,     ST_OK},
    '{CMD_LOAD, 4'd12, 5'd31, 16'd1999,  1'b1, 4'd12, 5'd31, 16'd1999,  ST_OK},
    '{CMD_FWD,  4'd0,  5'd0,  16'd0,     1'b0, 4'd0,  5'd0,  16'd0,     ST_OK}
  };

  // What travels with each request from the sender to the point where the
  // block accepts it: a result fixed by the table, if there is one.
  typedef struct packed {
    logic pinned;
    res_t date;
  } pinned_t;

  logic clk;
  logic rst_n;

  cds_req_if cmd_ch ();
  cds_res_if date_ch ();

  calendar_date_stepper DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (cmd_ch),
    .out_res (date_ch)
  );

  // The predictor's own copy of the date.
  month_t cal_month = RST_MONTH;
  day_t   cal_day   = RST_DAY;
  year_t  cal_year  = RST_YEAR;

  pinned_t pinned_q [$];
  res_t    dates_due [$];

  int unsigned sent_cnt     = 0;
  int unsigned accepted_cnt = 0;
  int unsigned results_cnt  = 0;
  int unsigned fail_cnt     = 0;
  logic        hold_done    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Gregorian rule: every fourth year, but not a century unless the century
  // is a multiple of 400.
  function automatic bit gregorian_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return gregorian_leap(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // Applies one command to the predicted date and returns the result that
  // the block must give for it.
  function automatic res_t next_date(input req_t r);
    res_t        o;
    status_t     st;
    int unsigned m, d, y, ld_m, ld_d, ld_y;
    st   = ST_OK;
    m    = 32'(cal_month);
    d    = 32'(cal_day);
    y    = 32'(cal_year);
    ld_m = 32'(r.new_month);
    ld_d = 32'(r.new_day);
    ld_y = 32'(r.new_year);
    case (r.cmd)
      CMD_LOAD: begin
        // Checks go month, then year, then day; the first failure wins and
        // the date stays as it was.
        if (ld_m < 32'(MONTH_JAN) || ld_m > 32'(MONTH_DEC)) begin
          st = ST_BAD_MONTH;
        end else if (ld_y < 32'(YEAR_MIN) || ld_y > 32'(YEAR_MAX)) begin
          st = ST_BAD_YEAR;
        end else if (ld_d < 1 || ld_d > days_in_month(ld_m, ld_y)) begin
          st = ST_BAD_DAY;
        end else begin
          m = ld_m;
          d = ld_d;
          y = ld_y;
        end
      end
      CMD_FWD: begin
        if (d < days_in_month(m, y)) begin
          d++;
        end else if (m < 32'(MONTH_DEC)) begin
          m++;
          d = 1;
        end else if (y >= 32'(YEAR_MAX)) begin
          // December 31 of the last year: hold.
          st = ST_LIMIT;
        end else begin
          y++;
          m = 32'(MONTH_JAN);
          d = 1;
        end
      end
      CMD_BACK: begin
        if (d > 1) begin
          d--;
        end else if (m > 32'(MONTH_JAN)) begin
          m--;
          d = days_in_month(m, y);
        end else if (y <= 32'(YEAR_MIN)) begin
          // January 1 of year one: hold.
          st = ST_LIMIT;
        end else begin
          y--;
          m = 32'(MONTH_DEC);
          d = 31;
        end
      end
      default: begin
        // The unused command leaves the date alone and reports success.
      end
    endcase
    cal_month   = month_t'(m);
    cal_day     = day_t'(d);
    cal_year    = year_t'(y);
    o.month_out = cal_month;
    o.day_out   = cal_day;
    o.year_out  = YIN_W'(cal_year);
    o.status    = st;
    return o;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  // Offers one request and waits until the block takes it. Between requests
  // the sender sometimes pauses for a short burst, except in calm windows and
  // in the quiet tail of the run. Valid stays high from one request to the
  // next when there is no pause.
  task automatic send_request(input req_t r, input logic pinned, input res_t date);
    pinned_t pin;
    if (sent_cnt < TOTAL_REQS - QUIET_TAIL && (sent_cnt / 150) % 4 != 3
        && $urandom_range(0, 5) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    pin.pinned = pinned;
    pin.date   = date;
    pinned_q.push_back(pin);
    cmd_ch.valid     <= 1'b1;
    cmd_ch.cmd       <= r.cmd;
    cmd_ch.new_month <= r.new_month;
    cmd_ch.new_day   <= r.new_day;
    cmd_ch.new_year  <= r.new_year;
    do @(posedge clk); while (cmd_ch.ready !== 1'b1);
    sent_cnt++;
  endtask

  // Both channels are sampled at the rising edge, where a transfer takes
  // place. An accepted request runs through the predictor at once, so the
  // expected results queue up in the order the block must return them.
  always @(posedge clk) begin : watch_channels
    req_t    r;
    res_t    want;
    res_t    got;
    pinned_t pin;
    if (rst_n) begin
      if (cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) begin
        r.cmd       = cmd_ch.cmd;
        r.new_month = cmd_ch.new_month;
        r.new_day   = cmd_ch.new_day;
        r.new_year  = cmd_ch.new_year;
        want = next_date(r);
        pin  = pinned_q.pop_front();
        if (pin.pinned) begin
          want = pin.date;
        end
        dates_due.push_back(want);
        accepted_cnt++;
      end
      if (date_ch.valid === 1'b1 && date_ch.ready === 1'b1) begin
        got.month_out = date_ch.month_out;
        got.day_out   = date_ch.day_out;
        got.year_out  = date_ch.year_out;
        got.status    = date_ch.status;
        results_cnt++;
        if (dates_due.size() == 0) begin
          $display("%0t ns: result with no request waiting, expected none, actual %0d/%0d/%0d st %0d",
                   $time, got.month_out, got.day_out, got.year_out, got.status);
          fail_cnt++;
        end else begin
          want = dates_due.pop_front();
          check_field("month_out", 32'(want.month_out), 32'(got.month_out));
          check_field("day_out",   32'(want.day_out),   32'(got.day_out));
          check_field("year_out",  32'(want.year_out),  32'(got.year_out));
          check_field("status",    32'(want.status),    32'(got.status));
        end
      end
    end
  end

  // Result sink. Ready drops in short random bursts outside calm windows and
  // the quiet tail. Once, after enough requests, it stays low for a long
  // stretch while the sender keeps offering, so the block fills and has to
  // push back on its input.
  initial begin : drive_sink
    date_ch.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (!hold_done && accepted_cnt >= HOLD_AFTER) begin
        hold_done = 1'b1;
        date_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (results_cnt < TOTAL_REQS - QUIET_TAIL && (results_cnt / 150) % 4 != 1
                   && $urandom_range(0, 6) == 0) begin
        date_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      date_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Ends the run if the block stops making progress.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : run_test
    req_t        r;
    res_t        want;
    dir_row_t    row;
    cmd_t        dir;
    int unsigned yr, mon, len, day, steps;
    rst_n            <= 1'b0;
    cmd_ch.valid     <= 1'b0;
    cmd_ch.cmd       <= CMD_LOAD;
    cmd_ch.new_month <= '0;
    cmd_ch.new_day   <= '0;
    cmd_ch.new_year  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: walk the table in order.
    for (int i = 0; i < DIR_ROWS; i++) begin
      row         = DIR_TABLE[i];
      r.cmd       = row.cmd;
      r.new_month = row.new_month;
      r.new_day   = row.new_day;
      r.new_year  = row.new_year;
      want.month_out = row.month_out;
      want.day_out   = row.day_out;
      want.year_out  = row.year_out;
      want.status    = row.status;
      send_request(r, row.pinned, want);
    end

    // Random part. Most of it is a legal load placed near a month, year or
    // range boundary followed by a run of steps that carries the date across
    // it. The rest is loads that fail a check, random fields and the unused
    // command. Fields that a step ignores carry random noise.
    while (sent_cnt < TOTAL_REQS) begin
      r = req_t'($urandom);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: begin
          case ($urandom_range(0, 4))
            0:       yr = $urandom_range(1, 3);
            1:       yr = $urandom_range(65533, 65535);
            2:       yr = $urandom_range(1, 655) * 100;
            3:       yr = $urandom_range(1896, 2104);
            default: yr = $urandom_range(1, 65535);
          endcase
          if ($urandom_range(0, 2) == 0) begin
            mon = $urandom_range(0, 1) ? 32'(MONTH_DEC) : 32'(MONTH_JAN);
          end else begin
            mon = $urandom_range(1, 12);
          end
          len = days_in_month(mon, yr);
          case ($urandom_range(0, 2))
            0:       day = $urandom_range(1, 3);
            1:       day = $urandom_range(len - 2, len);
            default: day = $urandom_range(1, len);
          endcase
          r.cmd       = CMD_LOAD;
          r.new_month = month_t'(mon);
          r.new_day   = day_t'(day);
          r.new_year  = YIN_W'(yr);
          send_request(r, 1'b0, '0);
          dir   = $urandom_range(0, 1) ? CMD_FWD : CMD_BACK;
          steps = $urandom_range(1, 16);
          repeat (steps) begin
            r = req_t'($urandom);
            case ($urandom_range(0, 9))
              0:       r.cmd = (dir == CMD_FWD) ? CMD_BACK : CMD_FWD;
              1:       r.cmd = CMD_NONE;
              default: r.cmd = dir;
            endcase
            send_request(r, 1'b0, '0);
          end
        end
        7, 8: begin
          r.cmd = CMD_LOAD;
          case ($urandom_range(0, 3))
            0: r.new_month = $urandom_range(0, 1) ? month_t'(0)
                                                   : month_t'($urandom_range(13, 15));
            1: begin
              r.new_month = month_t'($urandom_range(1, 12));
              r.new_year  = '0;
            end
            2: begin
              // Day zero or a day past the end of a real month and year.
              r.new_month = month_t'($urandom_range(1, 12));
              if (r.new_year == '0) begin
                r.new_year = YIN_W'($urandom_range(1, 65535));
              end
              len = days_in_month(32'(r.new_month), 32'(r.new_year));
              r.new_day = (len == 31 || $urandom_range(0, 1) == 0)
                          ? day_t'(0) : day_t'($urandom_range(len + 1, 31));
            end
            default: begin
              // Fully random fields.
            end
          endcase
          send_request(r, 1'b0, '0);
        end
        default: begin
          // Random command with random fields; the unused code is common here.
          if ($urandom_range(0, 1) == 0) begin
            r.cmd = CMD_NONE;
          end
          send_request(r, 1'b0, '0);
        end
      endcase
    end
    cmd_ch.valid <= 1'b0;

    while (pinned_q.size() != 0 || dates_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
